@@ rtl/dltt_pkg.sv @@
// ----------------------------------------------------------------------------
// dltt_pkg
// shared types and constants of the delta-list task timer
// ----------------------------------------------------------------------------
`default_nettype none

package dltt_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int DLY_W     = 13;

    // one 10 ms tick: q = (x * 52429) >> 19 is exact for 16-bit x
    localparam logic [15:0] RECIP_10 = 16'd52429;
    localparam int          RECIP_SH = 19;

    localparam logic [4:0] NO_SLOT = 5'd16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [2:0] STAT_ADDED     = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_TICK_IDLE = 3'd2;
    localparam logic [2:0] STAT_FIRED     = 3'd3;
    localparam logic [2:0] STAT_CANCELLED = 3'd4;
    localparam logic [2:0] STAT_SLOT_FREE = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] delay_ms;
        logic [15:0] period_ms;
        logic [3:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] task_slot;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_DLY,
        S_DIV_PER,
        S_TICK_DEC,
        S_ENQ_CMP,
        S_ENQ_FIX,
        S_ENQ_INS,
        S_CAN_FIND,
        S_CAN_CREDIT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/delta_list_task_timer.sv @@
// ----------------------------------------------------------------------------
// delta_list_task_timer
// timer queue of task slots kept as a delta list, run by a small sequencer
// ----------------------------------------------------------------------------
// A command transfer happens at a rising edge with start high and busy low.
// Each command gives exactly one result, shown on o_result for one cycle with
// o_done high; the receiver cannot stall it, so it must take every result.
// Commands run on one shared 13-bit add/subtract/compare unit that walks the
// delta list one entry per cycle, plus one 16x16 multiplier for the divide by
// ten. An add divides delay and period by ten, walks to its insert position
// (up to 15), adjusts the entry that it goes in front of, if any, and inserts;
// a tick decrements the head and, if it is due, fires a one-shot slot or
// requeues a periodic slot by the same walk; a cancel walks to the slot,
// credits its delay to its successor, if any, and removes it. An empty-list
// tick, full, free slot and unused codes answer at once. No command runs
// longer than an add at the tail of a list of fifteen. busy is low in the
// cycle of the strobe, so a new command may transfer there. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_task_timer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire dltt_pkg::t_in_item  i_item,
    output logic                     busy,
    output logic                     o_done,
    output dltt_pkg::t_out_item      o_result
);
    import dltt_pkg::*;

    // sequencer and working registers
    t_state                r_state,  n_state;
    t_in_item              r_in,     n_in;
    logic [SLOT_W-1:0]     r_slot,   n_slot;    // slot being added, fired or cancelled
    logic [DLY_W-1:0]      r_acc,    n_acc;     // running delay during the list walk
    logic [CNT_W-1:0]      r_pos,    n_pos;     // list position of the walk
    logic [2:0]            r_fin_st, n_fin_st;  // status to report after an insert (add or requeue)
    logic                  r_done,   n_done;
    t_out_item             r_result, n_result;

    // slot table and delta list
    logic [DLY_W-1:0]      r_rel    [MAX_SLOTS];
    logic [DLY_W-1:0]      n_rel    [MAX_SLOTS];
    logic [DLY_W-1:0]      r_reload [MAX_SLOTS];
    logic [DLY_W-1:0]      n_reload [MAX_SLOTS];
    logic [SLOT_W-1:0]     r_order  [MAX_SLOTS];
    logic [SLOT_W-1:0]     n_order  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  r_used,   n_used;
    logic [CNT_W-1:0]      r_count,  n_count;

    // read ports and shared unit
    logic [SLOT_W-1:0]     q_addr;
    logic [SLOT_W-1:0]     ord_rd;
    logic [SLOT_W-1:0]     d_addr;
    logic [DLY_W-1:0]      dly_rd;
    logic [DLY_W-1:0]      alu_a;
    logic [DLY_W-1:0]      alu_b;
    logic                  alu_sub;
    logic [DLY_W:0]        alu_res;    // top bit is the borrow on subtract
    logic [15:0]           div_src;
    logic [31:0]           prod;
    logic [DLY_W-1:0]      quo;
    logic [DLY_W-1:0]      dec_val;

    // free slot search
    logic [SLOT_W-1:0]     free_idx;
    logic                  free_found;
    logic [SLOT_W-1:0]     sel_idx;
    logic                  sel_ok;

    // list moves
    logic                  pop_en;     // close the gap at r_pos
    logic                  ins_en;     // open a gap at r_pos and place r_slot

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // lowest free slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_idx   = SLOT_W'(k);
                free_found = 1'b1;
            end
        end
    end

    assign sel_idx = SLOT_W'(i_item.slot);
    assign sel_ok  = (CNT_W'(i_item.slot) < CNT_W'(MAX_SLOTS));

    // one address per table each cycle
    always_comb begin
        if (r_state == S_CAN_CREDIT) begin
            q_addr = SLOT_W'(r_pos + CNT_W'(1));   // successor of the cancelled entry
        end else begin
            q_addr = SLOT_W'(r_pos);
        end
        ord_rd = r_order[q_addr];
        d_addr = (r_state == S_CAN_FIND) ? r_slot : ord_rd;
        dly_rd = r_rel[d_addr];
    end

    // shared add/subtract/compare unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (r_state)
            S_TICK_DEC: begin
                alu_a = dly_rd;
                alu_b = DLY_W'(1);
            end
            S_ENQ_CMP: begin
                alu_a = r_acc;
                alu_b = dly_rd;
            end
            S_ENQ_FIX: begin
                alu_a = dly_rd;
                alu_b = r_acc;
            end
            S_CAN_CREDIT: begin
                alu_a   = dly_rd;
                alu_b   = r_acc;
                alu_sub = 1'b0;
            end
            default: begin
                alu_a = '0;
            end
        endcase
        if (alu_sub) begin
            alu_res = {1'b0, alu_a} - {1'b0, alu_b};
        end else begin
            alu_res = {1'b0, alu_a} + {1'b0, alu_b};
        end
    end

    // divide by ten through the reciprocal
    assign div_src = (r_state == S_DIV_DLY) ? r_in.delay_ms : r_in.period_ms;
    assign prod    = div_src * RECIP_10;
    assign quo     = prod[RECIP_SH +: DLY_W];
    assign dec_val = (dly_rd != '0) ? alu_res[DLY_W-1:0] : '0;

    // next state and outputs
    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_slot   = r_slot;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_fin_st = r_fin_st;
        n_done   = 1'b0;
        n_result = r_result;
        n_rel    = r_rel;
        n_reload = r_reload;
        n_used   = r_used;
        n_count  = r_count;
        pop_en   = 1'b0;
        ins_en   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in  = i_item;
                    n_pos = '0;
                    case (i_item.op)
                        OP_ADD: begin
                            if (!free_found || (r_count >= CNT_W'(MAX_SLOTS))) begin
                                n_done   = 1'b1;
                                n_result = '{status: STAT_FULL, task_slot: NO_SLOT};
                            end else begin
                                n_slot           = free_idx;
                                n_used[free_idx] = 1'b1;
                                n_fin_st         = STAT_ADDED;
                                n_state          = S_DIV_DLY;
                            end
                        end
                        OP_TICK: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_result = '{status: STAT_TICK_IDLE, task_slot: NO_SLOT};
                            end else begin
                                n_fin_st = STAT_FIRED;
                                n_state  = S_TICK_DEC;
                            end
                        end
                        OP_CANCEL: begin
                            if (!sel_ok || !r_used[sel_idx]) begin
                                n_done   = 1'b1;
                                n_result = '{status: STAT_SLOT_FREE, task_slot: NO_SLOT};
                            end else begin
                                n_slot  = sel_idx;
                                n_state = S_CAN_FIND;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{status: STAT_TICK_IDLE, task_slot: NO_SLOT};
                        end
                    endcase
                end
            end

            S_DIV_DLY: begin
                n_acc   = quo;
                n_state = S_DIV_PER;
            end

            S_DIV_PER: begin
                n_reload[r_slot] = quo;
                n_state          = S_ENQ_CMP;
            end

            S_TICK_DEC: begin
                // head sits at position zero
                n_slot         = ord_rd;
                n_rel[ord_rd]  = dec_val;
                if (dec_val != '0) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '{status: STAT_TICK_IDLE, task_slot: NO_SLOT};
                end else begin
                    // head fires; its delay is zero so the successor gains nothing
                    pop_en  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    if (r_reload[ord_rd] != '0) begin
                        n_acc   = r_reload[ord_rd];
                        n_state = S_ENQ_CMP;
                    end else begin
                        n_used[ord_rd] = 1'b0;
                        n_state        = S_IDLE;
                        n_done         = 1'b1;
                        n_result       = '{status: STAT_FIRED, task_slot: 5'(ord_rd)};
                    end
                end
            end

            S_ENQ_CMP: begin
                if (r_pos >= r_count) begin
                    n_state = S_ENQ_INS;
                end else if (alu_res[DLY_W]) begin
                    // new deadline is earlier: it goes in front of this entry
                    n_state = S_ENQ_FIX;
                end else begin
                    n_acc = alu_res[DLY_W-1:0];
                    n_pos = r_pos + CNT_W'(1);
                end
            end

            S_ENQ_FIX: begin
                n_rel[ord_rd] = alu_res[DLY_W-1:0];
                n_state       = S_ENQ_INS;
            end

            S_ENQ_INS: begin
                ins_en        = 1'b1;
                n_rel[r_slot] = r_acc;
                n_count       = r_count + CNT_W'(1);
                n_state       = S_IDLE;
                n_done        = 1'b1;
                n_result      = '{status: r_fin_st, task_slot: 5'(r_slot)};
            end

            S_CAN_FIND: begin
                if (r_pos >= r_count) begin
                    n_used[r_slot] = 1'b0;
                    n_state        = S_IDLE;
                    n_done         = 1'b1;
                    n_result       = '{status: STAT_CANCELLED, task_slot: 5'(r_slot)};
                end else if (ord_rd == r_slot) begin
                    n_acc = dly_rd;
                    if ((r_pos + CNT_W'(1)) < r_count) begin
                        n_state = S_CAN_CREDIT;
                    end else begin
                        // last entry: nothing to credit
                        pop_en         = 1'b1;
                        n_count        = r_count - CNT_W'(1);
                        n_used[r_slot] = 1'b0;
                        n_state        = S_IDLE;
                        n_done         = 1'b1;
                        n_result       = '{status: STAT_CANCELLED, task_slot: 5'(r_slot)};
                    end
                end else begin
                    n_pos = r_pos + CNT_W'(1);
                end
            end

            S_CAN_CREDIT: begin
                n_rel[ord_rd]  = alu_res[DLY_W-1:0];
                pop_en         = 1'b1;
                n_count        = r_count - CNT_W'(1);
                n_used[r_slot] = 1'b0;
                n_state        = S_IDLE;
                n_done         = 1'b1;
                n_result       = '{status: STAT_CANCELLED, task_slot: 5'(r_slot)};
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // list moves, every entry at once
        n_order = r_order;
        for (int k = 0; k < MAX_SLOTS; k++) begin
            if (pop_en && (CNT_W'(k) >= r_pos) && (k < MAX_SLOTS - 1)) begin
                n_order[k] = r_order[(k + 1) % MAX_SLOTS];
            end
            if (ins_en) begin
                if (CNT_W'(k) > r_pos) begin
                    n_order[k] = r_order[(k + MAX_SLOTS - 1) % MAX_SLOTS];
                end else if (CNT_W'(k) == r_pos) begin
                    n_order[k] = r_slot;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_used  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

    // payload and table contents
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_slot   <= n_slot;
        r_acc    <= n_acc;
        r_pos    <= n_pos;
        r_fin_st <= n_fin_st;
        r_result <= n_result;
        r_rel    <= n_rel;
        r_reload <= n_reload;
        r_order  <= n_order;
    end

endmodule

`default_nettype wire

@@ rtl/dltt_checker.sv @@
// ----------------------------------------------------------------------------
// dltt_checker
// port-level checks of the delta-list task timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module dltt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire dltt_pkg::t_in_item  i_item,
    input wire logic                busy,
    input wire logic                o_done,
    input wire dltt_pkg::t_out_item o_result
);
    import dltt_pkg::*;

    // an accepted command either starts work or answers at once
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command left no trace");

    // work ends only with a result transfer
    a_busy_ends_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

    // results without a slot carry the none code
    a_no_slot_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STAT_FULL || o_result.status == STAT_TICK_IDLE ||
                    o_result.status == STAT_SLOT_FREE)) |-> (o_result.task_slot == NO_SLOT))
        else $error("slotless result names a slot");

    // results with a slot name a real one
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STAT_ADDED || o_result.status == STAT_FIRED ||
                    o_result.status == STAT_CANCELLED)) |-> (o_result.task_slot < NO_SLOT))
        else $error("result slot out of range");

    // nothing but a command in flight produces a result
    a_done_needs_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n)) |-> ($past(busy) || $past(start)))
        else $error("result without a command");

endmodule

bind delta_list_task_timer dltt_checker u_dltt_checker (.*);

`default_nettype wire
